/* hdl/pambm_pkg.sv */
// ----------------------------------------------------------------------------
// pambm_pkg
// Sizes, coefficient tables and inter-stage types for the piecewise
// alpha-max-plus-beta-min magnitude pipeline.
// ----------------------------------------------------------------------------
package pambm_pkg;

    localparam int SampleWidth  = 16;
    localparam int CoefFracBits = 15;
    localparam int FieldWidth   = 16;

    localparam int CoefWidth   = CoefFracBits + 1;
    localparam int NumRegions  = 9;
    localparam int NumThr      = NumRegions - 1;
    localparam int RegionWidth = $clog2(NumRegions);
    localparam int ProdWidth   = SampleWidth + CoefWidth;
    localparam int LhsWidth    = SampleWidth + CoefFracBits;
    localparam int SumWidth    = ProdWidth + 1;
    localparam int ResWidth    = SumWidth - CoefFracBits;
    localparam int ExtWidth    = (SampleWidth > FieldWidth) ? SampleWidth : FieldWidth;

    localparam longint unsigned ThrScale = 64'd100000000000;
    localparam longint unsigned CfScale  = 64'd10000;

    typedef logic [SampleWidth-1:0] t_sample;
    typedef logic [CoefWidth-1:0]   t_coef;
    typedef logic [ProdWidth-1:0]   t_prod;
    typedef logic [RegionWidth-1:0] t_region;

    // ratio thresholds, round-half-up to F fractional bits
    localparam t_coef ThrCoef [NumThr] = '{
        t_coef'(((64'd9849140336  << CoefFracBits) + ThrScale / 2) / ThrScale),
        t_coef'(((64'd19891236738 << CoefFracBits) + ThrScale / 2) / ThrScale),
        t_coef'(((64'd30334668361 << CoefFracBits) + ThrScale / 2) / ThrScale),
        t_coef'(((64'd41421356237 << CoefFracBits) + ThrScale / 2) / ThrScale),
        t_coef'(((64'd53451113595 << CoefFracBits) + ThrScale / 2) / ThrScale),
        t_coef'(((64'd66817863792 << CoefFracBits) + ThrScale / 2) / ThrScale),
        t_coef'(((64'd78000000000 << CoefFracBits) + ThrScale / 2) / ThrScale),
        t_coef'(((64'd82067879083 << CoefFracBits) + ThrScale / 2) / ThrScale)
    };

    localparam t_coef AlphaCoef [NumRegions] = '{
        t_coef'(((64'd12012 << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd9940  << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd9772  << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd9510  << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd9156  << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd8744  << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd8178  << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd8188  << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd7084  << CoefFracBits) + CfScale / 2) / CfScale)
    };

    localparam t_coef BetaCoef [NumRegions] = '{
        t_coef'(((64'd246  << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd1226 << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd2194 << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd3142 << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd4059 << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd4936 << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd5767 << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd5767 << CoefFracBits) + CfScale / 2) / CfScale),
        t_coef'(((64'd7042 << CoefFracBits) + CfScale / 2) / CfScale)
    };

    typedef struct packed {
        logic    valid;
        t_sample mx;
        t_sample mn;
    } t_minmax;

    typedef struct packed {
        logic    valid;
        t_sample mx;
        t_sample mn;
        t_region region;
    } t_classed;

endpackage

/* hdl/pambm_region.sv */
// ----------------------------------------------------------------------------
// pambm_region
// Two-stage region classifier: threshold products of max, then compare
// against min and priority-select the first region whose test passes.
// ----------------------------------------------------------------------------
module pambm_region (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pambm_pkg::t_minmax   i_item,
    output pambm_pkg::t_classed  o_item
);
    import pambm_pkg::*;

    logic    r_valid;
    t_sample r_mx;
    t_sample r_mn;
    t_prod   r_prod [NumThr];

    logic    n_valid;
    t_region n_region;
    t_prod   w_lhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx <= i_item.mx;
        r_mn <= i_item.mn;
        for (int i = 0; i < NumThr; i++) begin
            r_prod[i] <= ProdWidth'(ThrCoef[i]) * ProdWidth'(i_item.mx);
        end
    end

    assign w_lhs   = ProdWidth'({r_mn, {CoefFracBits{1'b0}}});
    assign n_valid = r_valid;

    always_comb begin
        n_region = RegionWidth'(NumRegions - 1);
        for (int i = NumThr - 1; i >= 0; i--) begin
            if (w_lhs < r_prod[i]) begin
                n_region = RegionWidth'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_item.valid <= 1'b0;
        end else begin
            o_item.valid <= n_valid;
        end
        o_item.mx     <= r_mx;
        o_item.mn     <= r_mn;
        o_item.region <= n_region;
    end

endmodule

/* hdl/piecewise_ambm_magnitude.sv */
// ----------------------------------------------------------------------------
// piecewise_ambm_magnitude
// Approximate modulus of a complex sample by nine-region
// alpha-max-plus-beta-min, fixed-point coefficients, rounded to nearest.
// ----------------------------------------------------------------------------
// Five-stage pipeline taking one item per clock; busy is always low. The
// magnitude of each accepted item is driven, in order of acceptance, with
// o_valid high for one cycle. Stages: abs/min/max, threshold products,
// region select, coefficient products, round and saturate. Results cannot
// be held off.
module piecewise_ambm_magnitude (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    input  logic signed [pambm_pkg::FieldWidth-1:0]  i_real_part,
    input  logic signed [pambm_pkg::FieldWidth-1:0]  i_imag_part,
    output logic                                     busy,
    output logic                                     o_valid,
    output logic        [pambm_pkg::FieldWidth-1:0]  o_magnitude
);
    import pambm_pkg::*;

    function automatic t_sample abs_s(input t_sample x);
        if (x[SampleWidth-1]) begin
            return ~x + t_sample'(1);
        end
        return x;
    endfunction

    logic [ExtWidth-1:0] w_re_ext;
    logic [ExtWidth-1:0] w_im_ext;
    t_sample             w_re_abs;
    t_sample             w_im_abs;

    t_minmax  r_mm;
    t_minmax  n_mm;
    t_classed w_cls;

    logic  r_prod_valid;
    t_prod r_pa;
    t_prod r_pb;

    logic [SumWidth-1:0]  w_sum;
    logic [ResWidth-1:0]  w_res;
    t_sample              n_sat;
    logic [ExtWidth-1:0]  w_sat_ext;

    logic                  r_valid;
    logic [FieldWidth-1:0] r_mag;

    assign busy = 1'b0;

    // stage 1: absolute values, max and min
    assign w_re_ext = ExtWidth'($unsigned(i_real_part));
    assign w_im_ext = ExtWidth'($unsigned(i_imag_part));
    assign w_re_abs = abs_s(w_re_ext[SampleWidth-1:0]);
    assign w_im_abs = abs_s(w_im_ext[SampleWidth-1:0]);

    always_comb begin
        n_mm.valid = start && !busy;
        if (w_re_abs < w_im_abs) begin
            n_mm.mx = w_im_abs;
            n_mm.mn = w_re_abs;
        end else begin
            n_mm.mx = w_re_abs;
            n_mm.mn = w_im_abs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm.valid <= 1'b0;
        end else begin
            r_mm.valid <= n_mm.valid;
        end
        r_mm.mx <= n_mm.mx;
        r_mm.mn <= n_mm.mn;
    end

    // stages 2 and 3
    pambm_region u_region (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_mm),
        .o_item  (w_cls)
    );

    // stage 4: coefficient products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= w_cls.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa <= ProdWidth'(AlphaCoef[w_cls.region]) * ProdWidth'(w_cls.mx);
        r_pb <= ProdWidth'(BetaCoef[w_cls.region]) * ProdWidth'(w_cls.mn);
    end

    // stage 5: sum, round, saturate
    assign w_sum = SumWidth'(r_pa) + SumWidth'(r_pb)
                 + (SumWidth'(1) << (CoefFracBits - 1));
    assign w_res = w_sum[SumWidth-1:CoefFracBits];

    always_comb begin
        if (w_res > ResWidth'({SampleWidth{1'b1}})) begin
            n_sat = {SampleWidth{1'b1}};
        end else begin
            n_sat = w_res[SampleWidth-1:0];
        end
    end

    assign w_sat_ext = ExtWidth'(n_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= w_sat_ext[FieldWidth-1:0];
    end

    assign o_valid     = r_valid;
    assign o_magnitude = r_mag;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted item did not produce a result after five cycles");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_real_part == 0 && i_imag_part == 0)
            |-> ##5 (o_valid && o_magnitude == 0))
        else $error("zero sample gave a nonzero magnitude");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!start && !$past(start, 1) && !$past(start, 2) && !$past(start, 3)
            && !$past(start, 4) && $past(i_rst_n, 5)) |-> ##1 !o_valid)
        else $error("result strobe without an accepted item");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the piecewise alpha-max-plus-beta-min magnitude
// block. Samples are sent in random bursts with random gaps between them.
// A monitor predicts the magnitude of every accepted sample and compares it
// with the results as they come out, in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int W      = pambm_pkg::FieldWidth;
    localparam int SW     = pambm_pkg::SampleWidth;
    localparam int F      = pambm_pkg::CoefFracBits;
    localparam int NEDGE  = 8;
    localparam int NREG   = 9;
    localparam int DRAIN  = 12;

    localparam longint unsigned EDGE_SCALE = 64'd100000000000;
    localparam longint unsigned COEF_SCALE = 64'd10000;

    // ratio edges in units of 1e-11, coefficient pairs in units of 1e-4
    localparam longint unsigned RATIO_EDGE_DEC [NEDGE] = '{
        64'd9849140336, 64'd19891236738, 64'd30334668361, 64'd41421356237,
        64'd53451113595, 64'd66817863792, 64'd78000000000, 64'd82067879083
    };
    localparam longint unsigned ALPHA_DEC [NREG] = '{
        64'd12012, 64'd9940, 64'd9772, 64'd9510, 64'd9156,
        64'd8744, 64'd8178, 64'd8188, 64'd7084
    };
    localparam longint unsigned BETA_DEC [NREG] = '{
        64'd246, 64'd1226, 64'd2194, 64'd3142, 64'd4059,
        64'd4936, 64'd5767, 64'd5767, 64'd7042
    };

    typedef struct {
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic        [W-1:0] mag;
    } t_mag_item;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic signed [W-1:0] i_real_part;
    logic signed [W-1:0] i_imag_part;
    logic                busy;
    logic                o_valid;
    logic        [W-1:0] o_magnitude;

    t_mag_item   mag_queue [$];
    int unsigned mismatches;
    int unsigned burst_left;

    piecewise_ambm_magnitude dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_real_part (i_real_part),
        .i_imag_part (i_imag_part),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_magnitude (o_magnitude)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint unsigned q_fixed(longint unsigned v, longint unsigned scale);
        return ((v << F) + scale / 2) / scale;
    endfunction

    function automatic logic [W-1:0] ambm_magnitude_of(logic signed [W-1:0] re,
                                                       logic signed [W-1:0] im);
        longint          sr;
        longint          si;
        longint unsigned a;
        longint unsigned b;
        longint unsigned mx;
        longint unsigned mn;
        longint unsigned sum;
        longint unsigned res;
        longint unsigned lim;
        int              k;
        sr = longint'(re);
        si = longint'(im);
        a  = (sr < 0) ? longint'(-sr) : sr;
        b  = (si < 0) ? longint'(-si) : si;
        mx = (a < b) ? b : a;
        mn = (a < b) ? a : b;
        k  = NREG - 1;
        for (int i = NEDGE - 1; i >= 0; i--) begin
            if ((mn << F) < q_fixed(RATIO_EDGE_DEC[i], EDGE_SCALE) * mx)
                k = i;
        end
        sum = q_fixed(ALPHA_DEC[k], COEF_SCALE) * mx + q_fixed(BETA_DEC[k], COEF_SCALE) * mn;
        res = (sum + (64'd1 << (F - 1))) >> F;
        lim = (64'd1 << SW) - 1;
        if (res > lim)
            res = lim;
        return res[W-1:0];
    endfunction

    task automatic report_mismatch(string what, t_mag_item item, logic [W-1:0] got);
        $display("MISMATCH %s: re=%0d im=%0d expected=%0d got=%0d",
                 what, item.re, item.im, item.mag, got);
        mismatches++;
    endtask

    // result check first, then record the item accepted at this edge
    always @(posedge i_clk) begin
        t_mag_item head;
        t_mag_item taken;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (mag_queue.size() == 0) begin
                    head = '{re: '0, im: '0, mag: '0};
                    report_mismatch("result with no item pending", head, o_magnitude);
                end else begin
                    head = mag_queue.pop_front();
                    if (o_magnitude !== head.mag)
                        report_mismatch("magnitude", head, o_magnitude);
                end
            end
            if (start && busy === 1'b0) begin
                taken.re  = i_real_part;
                taken.im  = i_imag_part;
                taken.mag = ambm_magnitude_of(i_real_part, i_imag_part);
                mag_queue.push_back(taken);
            end
        end
    end

    task automatic send_sample(logic signed [W-1:0] re, logic signed [W-1:0] im);
        int unsigned gap;
        int unsigned pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                gap = 0;
            else if (pick < 9)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(10, 30);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start       <= 1'b1;
        i_real_part <= re;
        i_imag_part <= im;
        do @(posedge i_clk); while (busy !== 1'b0);
        burst_left--;
    endtask

    // signed part of absolute value v; 2^(W-1) exists only as negative
    function automatic logic signed [W-1:0] part_of(longint unsigned v, bit neg);
        longint sv;
        sv = longint'(v);
        if (v == (64'd1 << (W - 1)) || neg)
            sv = -sv;
        return sv[W-1:0];
    endfunction

    task automatic test_extremes();
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0, -16'sd32768);
        send_sample(16'sd32767, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(-16'sd1, -16'sd1);
    endtask

    // mx = 2^(W-1) puts each edge exactly on an integer mn
    task automatic test_region_edges();
        longint unsigned t;
        for (int i = 0; i < NEDGE; i++) begin
            t = q_fixed(RATIO_EDGE_DEC[i], EDGE_SCALE);
            send_sample(-16'sd32768, part_of(t, i[0]));
            send_sample(part_of(t - 1, i[1]), -16'sd32768);
        end
    endtask

    task automatic test_random_full(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_sample(W'($urandom), W'($urandom));
    endtask

    task automatic test_random_regions(int unsigned n);
        int unsigned     k;
        longint unsigned mx;
        longint unsigned mn;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned r;
        logic signed [W-1:0] pa;
        logic signed [W-1:0] pb;
        for (int unsigned i = 0; i < n; i++) begin
            k  = $urandom_range(0, NREG - 1);
            mx = ($urandom_range(0, 15) == 0) ? (64'd1 << (W - 1))
                                              : $urandom_range(1, (1 << (W - 1)) - 1);
            lo = (k == 0) ? 0 : q_fixed(RATIO_EDGE_DEC[k-1], EDGE_SCALE);
            hi = (k == NREG - 1) ? (64'd1 << F) : q_fixed(RATIO_EDGE_DEC[k], EDGE_SCALE);
            r  = lo + longint'($urandom_range(0, int'(hi - lo)));
            mn = (mx * r) >> F;
            if (mn > mx)
                mn = mx;
            pa = part_of(mx, 1'($urandom_range(0, 1)));
            pb = part_of(mn, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                send_sample(pa, pb);
            else
                send_sample(pb, pa);
        end
    endtask

    task automatic test_random_tiny(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_sample(W'($urandom_range(0, 16)) - W'(8), W'($urandom_range(0, 16)) - W'(8));
    endtask

    initial begin
        mismatches  = 0;
        burst_left  = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_real_part <= '0;
        i_imag_part <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_region_edges();
        test_random_full(600);
        test_random_regions(650);
        test_random_tiny(250);

        start <= 1'b0;
        while (mag_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mag_queue.size() != 0) begin
            $display("MISMATCH %0d items left without a result", mag_queue.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TIMEOUT");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
